@@ rtl/edf_pkg.sv @@
// Package for the EDF periodic task scheduler: item types, slot-file
// access structs and operation codes. No dependencies.
`default_nettype none
package edf_pkg;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [2:0]  task_slot;
      logic [15:0] exec_time;
      logic [15:0] period_len;
      logic [15:0] instance_count;
   } edf_req_type;

   typedef struct packed {
      logic        cpu_busy;
      logic [2:0]  running_slot;
      logic        started;
      logic        preempted;
      logic        finished;
      logic [7:0]  miss_mask;
      logic        all_done;
      logic [15:0] miss_total;
   } edf_rsp_type;

   // One slot's stored fields.
   typedef struct packed {
      logic [15:0] exec_time;
      logic [15:0] period;
      logic [15:0] remaining;
      logic [15:0] units_left;
      logic [31:0] deadline;
      logic [15:0] countdown;
   } edf_slot_type;

   // Write request to the slot file: per-field enables plus new values.
   typedef struct packed {
      logic         en_exec;
      logic         en_period;
      logic         en_remaining;
      logic         en_units_left;
      logic         en_deadline;
      logic         en_countdown;
      edf_slot_type data;
   } edf_wr_type;

endpackage
`default_nettype wire

@@ rtl/edf_periodic_task_scheduler_core.sv @@
// EDF scheduler core. A load item writes its slot and gives no result. A
// tick item, once accepted, runs a drop check, a release step per slot in
// use through the slot file, a select step, a run step, a completion check
// per slot in use and an output step that waits while a result is unaccepted;
// the slot file's single access port sets these steps. Synchronous active-high
// reset puts every slot at its reset value, the CPU idle and task_count at 1.
`default_nettype none
module edf_periodic_task_scheduler_core #(
   parameter int MAX_TASKS = 8
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  edf_pkg::edf_req_type req_item,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output edf_pkg::edf_rsp_type rsp_item,
   input  wire                  csr_psel,
   input  wire                  csr_penable,
   input  wire                  csr_pwrite,
   input  wire  [2:0]           csr_paddr,
   input  wire  [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);
   import edf_pkg::*;

   // Only slots that a load can reach ever hold work.
   localparam int NS    = (MAX_TASKS < 8) ? MAX_TASKS : 8;
   localparam int IDX_W = (NS > 1) ? $clog2(NS) : 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DROP = 3'd1;
   localparam logic [2:0] ST_REL  = 3'd2;
   localparam logic [2:0] ST_SEL  = 3'd3;
   localparam logic [2:0] ST_RUN  = 3'd4;
   localparam logic [2:0] ST_CHK  = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [NS-1:0]    queued_ff, queued_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic             cur_valid_ff, cur_valid_in;
   logic [15:0]      miss_ff, miss_in;
   logic [3:0]       task_count_ff, task_count_in;
   logic [IDX_W-1:0] best_ff, best_in;
   logic             have_ff, have_in;
   logic [31:0]      best_dl_ff, best_dl_in;
   logic [7:0]       mask_ff, mask_in;
   logic             busy_ff, busy_in;
   logic             started_ff, started_in;
   logic             preempted_ff, preempted_in;
   logic             finished_ff, finished_in;
   logic             done_ff, done_in;
   logic             rsp_valid_ff, rsp_valid_in;
   edf_rsp_type      rsp_ff, rsp_in;

   logic [IDX_W-1:0] addr;
   edf_wr_type       wr;
   edf_slot_type     rd;
   logic [3:0]       n_use;
   logic             last_idx;
   logic [15:0]      rem_dec, tl_dec, period_ld;
   logic             q_new;
   logic [31:0]      dl_new;
   logic             req_fire;

   edf_slot_file #(.NUM_SLOTS(NS), .IDX_W(IDX_W)) u_slots (
      .clock (clock),
      .reset (reset),
      .addr  (addr),
      .wr    (wr),
      .rd    (rd)
   );

   assign n_use      = (task_count_ff > 4'(NS)) ? 4'(NS) : task_count_ff;
   assign last_idx   = ({{(4-IDX_W){1'b0}}, idx_ff} == (n_use - 4'd1));
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_item   = rsp_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 3'd0) ? {28'd0, task_count_ff} : 32'd0;
   assign rem_dec    = rd.remaining - 16'd1;
   assign period_ld  = (req_item.period_len == 16'd0) ? 16'd1 : req_item.period_len;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      queued_in     = queued_ff;
      cur_in        = cur_ff;
      cur_valid_in  = cur_valid_ff;
      miss_in       = miss_ff;
      task_count_in = task_count_ff;
      best_in       = best_ff;
      have_in       = have_ff;
      best_dl_in    = best_dl_ff;
      mask_in       = mask_ff;
      busy_in       = busy_ff;
      started_in    = started_ff;
      preempted_in  = preempted_ff;
      finished_in   = finished_ff;
      done_in       = done_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      addr          = idx_ff;
      wr            = '0;
      q_new         = 1'b0;
      dl_new        = rd.deadline;
      tl_dec        = (rd.units_left != 16'd0) ? rd.units_left - 16'd1 : 16'd0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 3'd0) begin
         task_count_in = csr_pwdata[3:0];
      end

      case (state_ff)
         ST_IDLE: begin
            addr = req_item.task_slot[IDX_W-1:0];
            if (req_fire) begin
               if (req_item.operation == OP_LOAD) begin
                  if ({1'b0, req_item.task_slot} < 4'(NS)) begin
                     wr.en_exec           = 1'b1;
                     wr.en_period         = 1'b1;
                     wr.en_remaining      = 1'b1;
                     wr.en_units_left     = 1'b1;
                     wr.en_deadline       = 1'b1;
                     wr.en_countdown      = 1'b1;
                     wr.data.exec_time    = req_item.exec_time;
                     wr.data.period       = period_ld;
                     wr.data.remaining    = req_item.instance_count;
                     wr.data.units_left   = req_item.exec_time;
                     wr.data.deadline     = {16'd0, period_ld};
                     wr.data.countdown    = 16'd0;
                     queued_in[req_item.task_slot[IDX_W-1:0]] = 1'b0;
                     if (cur_valid_ff && cur_ff == req_item.task_slot[IDX_W-1:0]) begin
                        cur_valid_in = 1'b0;
                     end
                  end
               end else begin
                  mask_in      = '0;
                  busy_in      = 1'b0;
                  started_in   = 1'b0;
                  preempted_in = 1'b0;
                  finished_in  = 1'b0;
                  state_in     = ST_DROP;
               end
            end
         end
         ST_DROP: begin
            addr = cur_ff;
            if (cur_valid_ff) begin
               if ({{(4-IDX_W){1'b0}}, cur_ff} >= n_use) begin
                  cur_valid_in = 1'b0;
               end else if (rd.countdown == 16'd0) begin
                  // The running instance hit its boundary unfinished.
                  cur_valid_in = 1'b0;
                  if (rd.remaining != 16'd0) begin
                     queued_in[cur_ff] = 1'b1;
                  end
               end
            end
            idx_in   = '0;
            have_in  = 1'b0;
            state_in = (n_use == 4'd0) ? ST_SEL : ST_REL;
         end
         ST_REL: begin
            q_new = queued_ff[idx_ff];
            wr.en_countdown = 1'b1;
            if (rd.countdown == 16'd0) begin
               wr.data.countdown = rd.period - 16'd1;
               if (rd.remaining != 16'd0) begin
                  if (!queued_ff[idx_ff]) begin
                     q_new = 1'b1;
                  end else begin
                     // Still pending at the next release: a missed instance.
                     mask_in[3'(idx_ff)] = 1'b1;
                     if (miss_ff != 16'hFFFF) begin
                        miss_in = miss_ff + 16'd1;
                     end
                     dl_new              = rd.deadline + {16'd0, rd.period};
                     wr.en_units_left    = 1'b1;
                     wr.en_deadline      = 1'b1;
                     wr.en_remaining     = 1'b1;
                     wr.data.units_left  = rd.exec_time;
                     wr.data.deadline    = dl_new;
                     wr.data.remaining   = rem_dec;
                     if (rem_dec == 16'd0) begin
                        q_new = 1'b0;
                     end
                  end
               end
            end else begin
               wr.data.countdown = rd.countdown - 16'd1;
            end
            queued_in[idx_ff] = q_new;
            if (q_new && (!have_in || dl_new < best_dl_ff)) begin
               have_in    = 1'b1;
               best_in    = idx_ff;
               best_dl_in = dl_new;
            end
            idx_in = idx_ff + 1'b1;
            if (last_idx) begin
               state_in = ST_SEL;
            end
         end
         ST_SEL: begin
            addr = cur_ff;
            if (!cur_valid_ff) begin
               if (have_ff) begin
                  queued_in[best_ff] = 1'b0;
                  cur_in             = best_ff;
                  cur_valid_in       = 1'b1;
                  started_in         = 1'b1;
               end
            end else if (have_ff && best_dl_ff < rd.deadline) begin
               queued_in[cur_ff]  = 1'b1;
               queued_in[best_ff] = 1'b0;
               cur_in             = best_ff;
               started_in         = 1'b1;
               preempted_in       = 1'b1;
            end
            state_in = ST_RUN;
         end
         ST_RUN: begin
            addr = cur_ff;
            if (cur_valid_ff) begin
               busy_in          = 1'b1;
               wr.en_units_left = 1'b1;
               if (tl_dec == 16'd0) begin
                  finished_in        = 1'b1;
                  wr.data.units_left = rd.exec_time;
                  wr.en_remaining    = 1'b1;
                  wr.data.remaining  = (rd.remaining != 16'd0) ? rem_dec : 16'd0;
                  wr.en_deadline     = 1'b1;
                  wr.data.deadline   = rd.deadline + {16'd0, rd.period};
                  queued_in[cur_ff]  = 1'b0;
                  cur_valid_in       = 1'b0;
               end else begin
                  wr.data.units_left = tl_dec;
               end
            end
            idx_in   = '0;
            done_in  = 1'b1;
            state_in = (n_use == 4'd0) ? ST_OUT : ST_CHK;
         end
         ST_CHK: begin
            if (rd.remaining != 16'd0) begin
               done_in = 1'b0;
            end
            idx_in = idx_ff + 1'b1;
            if (last_idx) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_in.cpu_busy     = busy_ff;
               rsp_in.running_slot = busy_ff ? 3'(cur_ff) : 3'd0;
               rsp_in.started      = started_ff;
               rsp_in.preempted    = preempted_ff;
               rsp_in.finished     = finished_ff;
               rsp_in.miss_mask    = mask_ff;
               rsp_in.all_done     = done_ff;
               rsp_in.miss_total   = miss_ff;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         queued_ff     <= '0;
         cur_ff        <= '0;
         cur_valid_ff  <= 1'b0;
         miss_ff       <= '0;
         task_count_ff <= 4'd1;
         have_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         queued_ff     <= queued_in;
         cur_ff        <= cur_in;
         cur_valid_ff  <= cur_valid_in;
         miss_ff       <= miss_in;
         task_count_ff <= task_count_in;
         have_ff       <= have_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff      <= best_in;
      best_dl_ff   <= best_dl_in;
      mask_ff      <= mask_in;
      busy_ff      <= busy_in;
      started_ff   <= started_in;
      preempted_ff <= preempted_in;
      finished_ff  <= finished_in;
      done_ff      <= done_in;
      rsp_ff       <= rsp_in;
   end

endmodule
`default_nettype wire

@@ rtl/edf_slot_file.sv @@
// Per-slot task state, accessed at one address a cycle for read and write.
// Depends on edf_pkg.
`default_nettype none
module edf_slot_file #(
   parameter int NUM_SLOTS = 8,
   parameter int IDX_W     = 3
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire [IDX_W-1:0]       addr,
   input  edf_pkg::edf_wr_type   wr,
   output edf_pkg::edf_slot_type rd
);
   import edf_pkg::*;

   edf_slot_type slot_ff [NUM_SLOTS];

   assign rd = slot_ff[addr];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_ff[i] <= '{exec_time: 16'd0, period: 16'd1, remaining: 16'd0,
                            units_left: 16'd0, deadline: 32'd0, countdown: 16'd0};
         end
      end else begin
         if (wr.en_exec)       slot_ff[addr].exec_time  <= wr.data.exec_time;
         if (wr.en_period)     slot_ff[addr].period     <= wr.data.period;
         if (wr.en_remaining)  slot_ff[addr].remaining  <= wr.data.remaining;
         if (wr.en_units_left) slot_ff[addr].units_left <= wr.data.units_left;
         if (wr.en_deadline)   slot_ff[addr].deadline   <= wr.data.deadline;
         if (wr.en_countdown)  slot_ff[addr].countdown  <= wr.data.countdown;
      end
   end

endmodule
`default_nettype wire

@@ tb/edf_periodic_task_scheduler_core_tb.sv @@
// Testbench for the EDF periodic task scheduler core: a directed table, then
// random load and tick items over several task_count settings and idling mixes.
// Depends on edf_pkg and edf_periodic_task_scheduler_core.
`default_nettype none
module edf_periodic_task_scheduler_core_tb;
   import edf_pkg::*;

   localparam int SLOTS = 8;
   localparam int DRAIN_CYCLES = 40;
   localparam int STALL_LIMIT = 5000;

   typedef struct {
      bit          is_cfg;
      logic [3:0]  cfg_value;
      edf_req_type req;
      bit          typed;
      edf_rsp_type rsp;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   edf_req_type          req_item;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   edf_rsp_type          rsp_item;
   logic                 csr_psel;
   logic                 csr_penable;
   logic                 csr_pwrite;
   logic [2:0]           csr_paddr;
   logic [31:0]          csr_pwdata;
   logic [31:0]          csr_prdata;
   logic                 csr_pready;

   // Scheduler state as the block should hold it.
   logic [3:0]  sched_task_count;
   logic [15:0] sched_exec [SLOTS];
   logic [15:0] sched_period [SLOTS];
   logic [15:0] sched_remaining [SLOTS];
   logic [15:0] sched_units_left [SLOTS];
   logic [31:0] sched_deadline [SLOTS];
   logic [15:0] sched_countdown [SLOTS];
   bit          sched_queued [SLOTS];
   logic [2:0]  sched_cur;
   bit          sched_cur_valid;
   logic [15:0] sched_misses;

   edf_rsp_type  pending_ticks [$];
   stim_row_type directed_rows [$];
   int           error_count = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   int           ticks_sent = 0;
   int           loads_sent = 0;
   int           preempts_seen = 0;
   int           misses_seen = 0;
   int           finishes_seen = 0;
   int           stall_cycles = 0;

   edf_periodic_task_scheduler_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch in %s: got %0h, expected %0h (t=%0t)", field, got, want, $time);
      error_count++;
   endtask

   task automatic add_row(input stim_row_type row);
      directed_rows.insert(directed_rows.size(), row);
   endtask

   task automatic sched_reset();
      sched_task_count = 4'd1;
      for (int i = 0; i < SLOTS; i++) begin
         sched_exec[i] = '0;
         sched_period[i] = 16'd1;
         sched_remaining[i] = '0;
         sched_units_left[i] = '0;
         sched_deadline[i] = '0;
         sched_countdown[i] = '0;
         sched_queued[i] = 1'b0;
      end
      sched_cur = '0;
      sched_cur_valid = 1'b0;
      sched_misses = '0;
   endtask

   task automatic sched_load(input edf_req_type it);
      logic [15:0] p;
      int s;
      s = int'(it.task_slot);
      p = (it.period_len == 0) ? 16'd1 : it.period_len;
      sched_exec[s] = it.exec_time;
      sched_period[s] = p;
      sched_remaining[s] = it.instance_count;
      sched_units_left[s] = it.exec_time;
      sched_deadline[s] = {16'd0, p};
      sched_countdown[s] = '0;
      sched_queued[s] = 1'b0;
      if (sched_cur_valid && sched_cur == s) sched_cur_valid = 1'b0;
   endtask

   task automatic sched_tick(output edf_rsp_type r);
      int n;
      int best;
      int c;
      bit done;
      r = '0;
      done = 1'b1;
      n = (sched_task_count > SLOTS) ? SLOTS : int'(sched_task_count);
      if (sched_cur_valid && sched_cur >= n) sched_cur_valid = 1'b0;
      // The running task at its boundary is requeued if instances remain.
      if (sched_cur_valid && sched_countdown[sched_cur] == 0) begin
         sched_cur_valid = 1'b0;
         if (sched_remaining[sched_cur] > 0) sched_queued[sched_cur] = 1'b1;
      end
      for (int i = 0; i < n; i++) begin
         if (sched_countdown[i] == 0) begin
            if (sched_remaining[i] > 0) begin
               if (!sched_queued[i]) begin
                  sched_queued[i] = 1'b1;
               end else begin
                  r.miss_mask[i] = 1'b1;
                  if (sched_misses != 16'hFFFF) sched_misses++;
                  sched_units_left[i] = sched_exec[i];
                  sched_deadline[i] += {16'd0, sched_period[i]};
                  sched_remaining[i]--;
                  if (sched_remaining[i] == 0) sched_queued[i] = 1'b0;
               end
            end
            sched_countdown[i] = sched_period[i] - 16'd1;
         end else begin
            sched_countdown[i]--;
         end
      end
      best = n;
      for (int i = 0; i < n; i++)
         if (sched_queued[i] && (best == n || sched_deadline[i] < sched_deadline[best]))
            best = i;
      if (!sched_cur_valid) begin
         if (best < n) begin
            sched_queued[best] = 1'b0;
            sched_cur = 3'(best);
            sched_cur_valid = 1'b1;
            r.started = 1'b1;
         end
      end else if (best < n && sched_deadline[best] < sched_deadline[sched_cur]) begin
         sched_queued[best] = 1'b0;
         sched_queued[sched_cur] = 1'b1;
         sched_cur = 3'(best);
         r.started = 1'b1;
         r.preempted = 1'b1;
      end
      if (sched_cur_valid) begin
         c = int'(sched_cur);
         r.cpu_busy = 1'b1;
         r.running_slot = sched_cur;
         if (sched_units_left[c] > 0) sched_units_left[c]--;
         if (sched_units_left[c] == 0) begin
            r.finished = 1'b1;
            sched_units_left[c] = sched_exec[c];
            if (sched_remaining[c] > 0) sched_remaining[c]--;
            sched_queued[c] = 1'b0;
            sched_cur_valid = 1'b0;
            sched_deadline[c] += {16'd0, sched_period[c]};
         end
      end
      for (int i = 0; i < n; i++)
         if (sched_remaining[i] != 0) done = 1'b0;
      r.all_done = done;
      r.miss_total = sched_misses;
   endtask

   // Offers one item and holds it until the block takes it.
   task automatic send_item(input edf_req_type it, input bit typed, input edf_rsp_type want);
      edf_rsp_type r;
      req_item <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if (it.operation == OP_TICK) begin
         sched_tick(r);
         pending_ticks.insert(pending_ticks.size(), typed ? want : r);
         ticks_sent++;
      end else begin
         sched_load(it);
         loads_sent++;
      end
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_ticks.size() != 0) @(posedge clock);
      // A trailing load may still be in flight.
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_task_count(input logic [3:0] value);
      drain();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= 3'd0;
      csr_pwdata <= {28'($urandom_range(32'h0FFF_FFFF)), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sched_task_count = value;
      @(posedge clock);
      if (csr_prdata !== {28'd0, value})
         report_mismatch("task_count readback", longint'(csr_prdata), longint'(value));
   endtask

   function automatic stim_row_type load_row(int s, int e, int p, int cnt);
      stim_row_type row;
      row = '{default: '0};
      row.req.operation = OP_LOAD;
      row.req.task_slot = 3'(s);
      row.req.exec_time = 16'(e);
      row.req.period_len = 16'(p);
      row.req.instance_count = 16'(cnt);
      return row;
   endfunction

   function automatic stim_row_type tick_row();
      stim_row_type row;
      row = '{default: '0};
      row.req = '1;
      row.req.operation = OP_TICK;
      return row;
   endfunction

   function automatic stim_row_type cfg_row(int value);
      stim_row_type row;
      row = '{default: '0};
      row.is_cfg = 1'b1;
      row.cfg_value = 4'(value);
      return row;
   endfunction

   function automatic edf_req_type random_item(int n);
      edf_req_type it;
      logic [63:0] raw;
      raw = {$urandom(), $urandom()};
      it = raw[$bits(edf_req_type)-1:0];
      if ($urandom_range(99) < 18) begin
         it.operation = OP_LOAD;
         if ($urandom_range(99) >= 5) begin
            it.task_slot = 3'((n > 0 && $urandom_range(9) != 0) ? $urandom_range(n - 1)
                                                                : $urandom_range(7));
            it.exec_time = 16'($urandom_range(5));
            it.period_len = 16'($urandom_range(12));
            it.instance_count = 16'($urandom_range(8));
         end
      end else begin
         it.operation = OP_TICK;
      end
      return it;
   endfunction

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      edf_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_ticks.size() == 0) begin
            $display("result with nothing expected (t=%0t)", $time);
            error_count++;
         end else begin
            want = pending_ticks.pop_front();
            if (rsp_item.cpu_busy !== want.cpu_busy)
               report_mismatch("cpu_busy", longint'(rsp_item.cpu_busy),
                               longint'(want.cpu_busy));
            if (rsp_item.running_slot !== want.running_slot)
               report_mismatch("running_slot", longint'(rsp_item.running_slot),
                               longint'(want.running_slot));
            if (rsp_item.started !== want.started)
               report_mismatch("started", longint'(rsp_item.started),
                               longint'(want.started));
            if (rsp_item.preempted !== want.preempted)
               report_mismatch("preempted", longint'(rsp_item.preempted),
                               longint'(want.preempted));
            if (rsp_item.finished !== want.finished)
               report_mismatch("finished", longint'(rsp_item.finished),
                               longint'(want.finished));
            if (rsp_item.miss_mask !== want.miss_mask)
               report_mismatch("miss_mask", longint'(rsp_item.miss_mask),
                               longint'(want.miss_mask));
            if (rsp_item.all_done !== want.all_done)
               report_mismatch("all_done", longint'(rsp_item.all_done),
                               longint'(want.all_done));
            if (rsp_item.miss_total !== want.miss_total)
               report_mismatch("miss_total", longint'(rsp_item.miss_total),
                               longint'(want.miss_total));
            preempts_seen += int'(want.preempted);
            finishes_seen += int'(want.finished);
            misses_seen += $countones(want.miss_mask);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
         $display("** edf_periodic_task_scheduler_core: FAILED **");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      stim_row_type row;
      logic [3:0] phase_counts [3];
      int phase_send [3];
      int phase_recv [3];
      int n;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_item <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      sched_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // After reset only slot 0 is in use and it has no instances.
      row = tick_row();
      row.typed = 1'b1;
      row.rsp.all_done = 1'b1;
      add_row(row);
      add_row(cfg_row(8));
      add_row(load_row(0, 2, 5, 3));
      add_row(load_row(1, 1, 3, 2));
      add_row(load_row(2, 0, 0, 1));
      add_row(load_row(7, 65535, 65535, 65535));
      add_row(load_row(4, 6, 4, 2));
      for (int i = 0; i < 10; i++) add_row(tick_row());
      add_row(load_row(4, 1, 2, 1));
      for (int i = 0; i < 3; i++) add_row(tick_row());
      add_row(cfg_row(1));
      add_row(tick_row());
      add_row(load_row(0, 0, 1, 0));
      add_row(tick_row());

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_cfg)
            write_task_count(directed_rows[i].cfg_value);
         else
            send_item(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);
      end

      phase_counts = '{4'd8, 4'd15, 4'd0};
      phase_send = '{22, 86, 0};
      phase_recv = '{86, 22, 0};
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = phase_send[ph];
         recv_idle_pct = phase_recv[ph];
         for (int seg = 0; seg < 3; seg++) begin
            if (seg == 0) write_task_count(phase_counts[ph]);
            else write_task_count(4'($urandom_range(8, 1)));
            n = (sched_task_count > SLOTS) ? SLOTS : int'(sched_task_count);
            // Start each setting from well-formed tasks in every slot in use.
            for (int s = 0; s < n; s++)
               send_item(load_row(s, $urandom_range(4, 1), $urandom_range(10, 2),
                                  $urandom_range(8, 1)).req, 1'b0, '0);
            for (int k = 0; k < 70; k++) begin
               if (seg == 1 && k == 35) drain();
               send_item(random_item(n), 1'b0, '0);
            end
         end
      end

      recv_idle_pct = 0;
      drain();
      $display("%0d ticks and %0d loads sent; %0d finishes, %0d preemptions, %0d misses seen",
               ticks_sent, loads_sent, finishes_seen, preempts_seen, misses_seen);
      if (error_count == 0) begin
         $display("** edf_periodic_task_scheduler_core: PASSED **");
      end else begin
         $display("%0d mismatches", error_count);
         $display("** edf_periodic_task_scheduler_core: FAILED **");
      end
      $finish;
   end
endmodule
`default_nettype wire

@@ edf_periodic_task_scheduler_core.f @@
rtl/edf_pkg.sv
rtl/edf_slot_file.sv
rtl/edf_periodic_task_scheduler_core.sv
tb/edf_periodic_task_scheduler_core_tb.sv
